>>> sv/hrf_pkg.sv
// Shared types, character codes and key tables for the HTTP request framer.
// Used by hrf_hdr_parser and http_request_framer; depends on nothing else.
package hrf_pkg;

  localparam int MAX_LENGTH_DIGITS = 12;
  localparam int LEN_W             = 40;   // content-length accumulator
  localparam int CNT_W             = 17;   // header byte counter
  localparam int KEY_POS_W         = 5;
  localparam int ENC_KEY_LEN       = 17;
  localparam int LEN_KEY_LEN       = 14;
  localparam int KEY_POS_CAP       = 31;

  localparam logic [LEN_W-1:0] LEN_CAP = {LEN_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_CAP = {CNT_W{1'b1}};

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_HDR_LARGE    = 3'd1,
    ST_TRANSFER_ENC = 3'd2,
    ST_BAD_LENGTH   = 3'd3,
    ST_BODY_LARGE   = 3'd4
  } status_t;

  typedef enum logic {
    REG_MAX_HEADER = 1'b0,
    REG_MAX_BODY   = 1'b1
  } reg_index_t;

  localparam logic [15:0] MAX_HEADER_RESET = 16'd8192;
  localparam logic [31:0] MAX_BODY_RESET   = 32'd1048576;

  // Header facts handed from the parser to the framing control.
  typedef struct packed {
    logic             enc_seen;
    logic             len_seen;
    logic             len_bad;
    logic [LEN_W-1:0] len_value;
  } hdr_info_t;

  typedef struct packed {
    logic [31:0] body_length;
    status_t     status;
    logic        last;
    logic        hdr_end;
    logic        in_body;
    logic [7:0]  out_byte;
  } out_res_t;

  // "transfer-encoding", lower case
  function automatic logic [7:0] enc_key_char(input logic [KEY_POS_W-1:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = 8'h74;
      5'd1:    ch = 8'h72;
      5'd2:    ch = 8'h61;
      5'd3:    ch = 8'h6E;
      5'd4:    ch = 8'h73;
      5'd5:    ch = 8'h66;
      5'd6:    ch = 8'h65;
      5'd7:    ch = 8'h72;
      5'd8:    ch = 8'h2D;
      5'd9:    ch = 8'h65;
      5'd10:   ch = 8'h6E;
      5'd11:   ch = 8'h63;
      5'd12:   ch = 8'h6F;
      5'd13:   ch = 8'h64;
      5'd14:   ch = 8'h69;
      5'd15:   ch = 8'h6E;
      5'd16:   ch = 8'h67;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "content-length", lower case
  function automatic logic [7:0] len_key_char(input logic [KEY_POS_W-1:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = 8'h63;
      5'd1:    ch = 8'h6F;
      5'd2:    ch = 8'h6E;
      5'd3:    ch = 8'h74;
      5'd4:    ch = 8'h65;
      5'd5:    ch = 8'h6E;
      5'd6:    ch = 8'h74;
      5'd7:    ch = 8'h2D;
      5'd8:    ch = 8'h6C;
      5'd9:    ch = 8'h65;
      5'd10:   ch = 8'h6E;
      5'd11:   ch = 8'h67;
      5'd12:   ch = 8'h74;
      5'd13:   ch = 8'h68;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> sv/hrf_hdr_parser.sv
// Header line parser: key matching, content-length value checking and accumulation.
// Depends on hrf_pkg.
module hrf_hdr_parser #(
  parameter int MAX_LENGTH_DIGITS = hrf_pkg::MAX_LENGTH_DIGITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               step,
  input  logic [7:0]         data_byte,
  output hrf_pkg::hdr_info_t info
);

  localparam int DC_W = $clog2(MAX_LENGTH_DIGITS + 2);

  typedef struct packed {
    logic                          in_value;
    logic [hrf_pkg::KEY_POS_W-1:0] key_pos;
    logic                          len_match;
    logic                          enc_match;
    logic                          in_len;
    logic                          len_seen;
    logic                          enc_seen;
    logic                          len_bad;
    logic [DC_W-1:0]               digits;
    logic                          trailing;
    logic                          pending_cr;
    logic [hrf_pkg::LEN_W-1:0]     value;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    in_value:   1'b0,
    key_pos:    '0,
    len_match:  1'b1,
    enc_match:  1'b1,
    in_len:     1'b0,
    len_seen:   1'b0,
    enc_seen:   1'b0,
    len_bad:    1'b0,
    digits:     '0,
    trailing:   1'b0,
    pending_cr: 1'b0,
    value:      '0
  };

  parse_state_t pstate;
  parse_state_t pstate_next;

  always_comb begin
    logic                        do_cr;
    logic                        do_eol;
    logic                        do_char;
    logic [7:0]                  lc;
    logic [DC_W-1:0]             dc_inc;
    logic [hrf_pkg::LEN_W+3:0]   mac;
    logic [hrf_pkg::LEN_W-1:0]   digit;
    pstate_next = pstate;
    do_cr       = 1'b0;
    do_eol      = 1'b0;
    do_char     = 1'b0;
    lc          = data_byte;
    dc_inc      = pstate.digits;
    digit       = hrf_pkg::LEN_W'(data_byte - hrf_pkg::CH_0);
    mac         = '0;

    // A held CR either closes the line (with LF) or becomes line content.
    if (pstate.pending_cr) begin
      pstate_next.pending_cr = 1'b0;
      if (data_byte == hrf_pkg::CH_LF) begin
        do_eol = 1'b1;
      end else begin
        do_cr = 1'b1;
      end
    end
    if (!do_eol) begin
      if (data_byte == hrf_pkg::CH_CR) begin
        pstate_next.pending_cr = 1'b1;
      end else begin
        do_char = 1'b1;
      end
    end

    // CR as content: never part of a key, never valid in a length value
    if (do_cr) begin
      if (!pstate_next.in_value) begin
        pstate_next.enc_match = 1'b0;
        pstate_next.len_match = 1'b0;
        if (pstate_next.key_pos < hrf_pkg::KEY_POS_W'(hrf_pkg::KEY_POS_CAP)) begin
          pstate_next.key_pos = pstate_next.key_pos + 1'b1;
        end
      end else if (pstate_next.in_len) begin
        pstate_next.len_bad = 1'b1;
      end
    end

    if (do_eol) begin
      if (pstate_next.in_len && pstate_next.digits == '0) begin
        pstate_next.len_bad = 1'b1;
      end
      pstate_next.in_len    = 1'b0;
      pstate_next.in_value  = 1'b0;
      pstate_next.key_pos   = '0;
      pstate_next.len_match = 1'b1;
      pstate_next.enc_match = 1'b1;
    end

    if (do_char) begin
      if (!pstate_next.in_value) begin
        if (data_byte == hrf_pkg::CH_COLON) begin
          if (pstate_next.enc_match &&
              pstate_next.key_pos == hrf_pkg::KEY_POS_W'(hrf_pkg::ENC_KEY_LEN)) begin
            pstate_next.enc_seen = 1'b1;
          end
          if (pstate_next.len_match && !pstate_next.len_seen &&
              pstate_next.key_pos == hrf_pkg::KEY_POS_W'(hrf_pkg::LEN_KEY_LEN)) begin
            pstate_next.len_seen = 1'b1;
            pstate_next.in_len   = 1'b1;
          end
          pstate_next.in_value = 1'b1;
        end else begin
          if (data_byte >= hrf_pkg::CH_A_UP && data_byte <= hrf_pkg::CH_Z_UP) begin
            lc = data_byte + hrf_pkg::CASE_GAP;
          end
          if (pstate_next.key_pos >= hrf_pkg::KEY_POS_W'(hrf_pkg::ENC_KEY_LEN) ||
              hrf_pkg::enc_key_char(pstate_next.key_pos) != lc) begin
            pstate_next.enc_match = 1'b0;
          end
          if (pstate_next.key_pos >= hrf_pkg::KEY_POS_W'(hrf_pkg::LEN_KEY_LEN) ||
              hrf_pkg::len_key_char(pstate_next.key_pos) != lc) begin
            pstate_next.len_match = 1'b0;
          end
          if (pstate_next.key_pos < hrf_pkg::KEY_POS_W'(hrf_pkg::KEY_POS_CAP)) begin
            pstate_next.key_pos = pstate_next.key_pos + 1'b1;
          end
        end
      end else if (pstate_next.in_len && !pstate_next.len_bad) begin
        if (data_byte == hrf_pkg::CH_SPACE || data_byte == hrf_pkg::CH_TAB) begin
          if (pstate_next.digits != '0) begin
            pstate_next.trailing = 1'b1;
          end
        end else if (data_byte >= hrf_pkg::CH_0 && data_byte <= hrf_pkg::CH_9 &&
                     !pstate_next.trailing) begin
          dc_inc = pstate_next.digits;
          if (dc_inc <= DC_W'(MAX_LENGTH_DIGITS)) begin
            dc_inc = dc_inc + 1'b1;
          end
          pstate_next.digits = dc_inc;
          if (dc_inc > DC_W'(MAX_LENGTH_DIGITS)) begin
            pstate_next.len_bad = 1'b1;
          end else begin
            // value * 10 + digit, saturating
            mac = {pstate_next.value, 3'b000} + {2'b00, pstate_next.value, 1'b0} +
                  {4'b0000, digit};
            if (mac > {4'b0000, hrf_pkg::LEN_CAP}) begin
              pstate_next.value = hrf_pkg::LEN_CAP;
            end else begin
              pstate_next.value = mac[hrf_pkg::LEN_W-1:0];
            end
          end
        end else begin
          pstate_next.len_bad = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pstate <= PARSE_RESET;
    end else if (step) begin
      pstate <= pstate_next;
    end
  end

  // The terminating LF only closes a line, so the stored value already holds
  // the final length when the header end is decided.
  assign info.enc_seen  = pstate_next.enc_seen;
  assign info.len_seen  = pstate_next.len_seen;
  assign info.len_bad   = pstate_next.len_bad;
  assign info.len_value = pstate.value;

endmodule

>>> sv/http_request_framer.sv
// Top level of the HTTP/1.x request framer: stream ports, APB registers, framing control
// and the output register with skid stage. Depends on hrf_pkg and hrf_hdr_parser.
//
//  Port group  Direction  Beat contents
//  s_*         in         tuser: command; tdata: data_byte
//  m_*         out        tdata: out_byte, status, body_length; tuser: in_body,
//                         hdr_end; tlast: last
//  p*          in/out     APB: max_header_bytes at 0x0, max_body_bytes at 0x4
//
// One beat per cycle while s_tready is high: parser and framing state update when a
// beat is accepted; the result enters the output or skid register on the same edge.
// A skid register keeps s_tready high for one beat while m_tready is low.
// A start command, or a beat after the request is complete, gives no output beat.
// rst is synchronous; it restores register defaults and starts a new request.
module http_request_framer #(
  parameter int MAX_LENGTH_DIGITS = hrf_pkg::MAX_LENGTH_DIGITS
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] command
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] out_byte, [10:8] status, [42:11] body_length
  output logic [1:0]  m_tuser,   // [0] in_body, [1] hdr_end
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_header_bytes;
  logic [31:0] max_body_bytes;

  hrf_pkg::phase_t               phase;
  hrf_pkg::phase_t               phase_next;
  logic [1:0]                    term;
  logic [1:0]                    term_next;
  logic [hrf_pkg::CNT_W-1:0]     header_count;
  logic [hrf_pkg::CNT_W-1:0]     header_count_next;
  logic [31:0]                   remaining;
  logic [31:0]                   remaining_next;

  hrf_pkg::hdr_info_t            info;
  hrf_pkg::status_t              hdr_status;
  hrf_pkg::out_res_t             res;
  logic                          res_valid;

  hrf_pkg::out_res_t             out_res;
  logic                          out_valid;
  hrf_pkg::out_res_t             skid_res;
  logic                          skid_valid;

  logic                          in_acc;
  logic                          data_acc;
  logic                          done_hdr;
  logic                          hdr_over;
  logic [31:0]                   body_len;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_header_bytes <= hrf_pkg::MAX_HEADER_RESET;
      max_body_bytes   <= hrf_pkg::MAX_BODY_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (hrf_pkg::reg_index_t'(paddr[2]))
        hrf_pkg::REG_MAX_HEADER: max_header_bytes <= pwdata[15:0];
        hrf_pkg::REG_MAX_BODY:   max_body_bytes   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (hrf_pkg::reg_index_t'(paddr[2]))
      hrf_pkg::REG_MAX_HEADER: prdata = {16'h0000, max_header_bytes};
      hrf_pkg::REG_MAX_BODY:   prdata = max_body_bytes;
      default:                 prdata = '0;
    endcase
  end

  // ---------------- input side ----------------
  assign s_tready = !skid_valid;
  assign in_acc   = s_tvalid && s_tready;
  assign data_acc = in_acc && (s_tuser == hrf_pkg::CMD_DATA);

  hrf_hdr_parser #(
    .MAX_LENGTH_DIGITS(MAX_LENGTH_DIGITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .clear     (in_acc && (s_tuser == hrf_pkg::CMD_START)),
    .step      (data_acc && (phase == hrf_pkg::PH_HEADER)),
    .data_byte (s_tdata),
    .info      (info)
  );

  // ---------------- header framing ----------------
  always_comb begin
    if (s_tdata == hrf_pkg::CH_CR) begin
      term_next = (term == 2'd2) ? 2'd3 : 2'd1;
    end else if (s_tdata == hrf_pkg::CH_LF) begin
      term_next = (term == 2'd1) ? 2'd2 : 2'd0;
    end else begin
      term_next = 2'd0;
    end
  end

  assign done_hdr = (s_tdata == hrf_pkg::CH_LF) && (term == 2'd3);
  assign header_count_next = (header_count == hrf_pkg::CNT_CAP) ?
                             header_count : header_count + 1'b1;
  assign hdr_over = header_count_next > hrf_pkg::CNT_W'(max_header_bytes);
  assign body_len = info.len_seen ? info.len_value[31:0] : 32'd0;
  assign remaining_next = (remaining != 32'd0) ? remaining - 1'b1 : remaining;

  always_comb begin
    if (info.enc_seen) begin
      hdr_status = hrf_pkg::ST_TRANSFER_ENC;
    end else if (info.len_seen && info.len_bad) begin
      hdr_status = hrf_pkg::ST_BAD_LENGTH;
    end else if (info.len_seen && info.len_value > hrf_pkg::LEN_W'(max_body_bytes)) begin
      hdr_status = hrf_pkg::ST_BODY_LARGE;
    end else begin
      hdr_status = hrf_pkg::ST_OK;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      hrf_pkg::PH_HEADER: begin
        if (done_hdr) begin
          if (hdr_status != hrf_pkg::ST_OK || body_len == 32'd0) begin
            phase_next = hrf_pkg::PH_DONE;
          end else begin
            phase_next = hrf_pkg::PH_BODY;
          end
        end else if (hdr_over) begin
          phase_next = hrf_pkg::PH_DONE;
        end
      end
      hrf_pkg::PH_BODY: begin
        if (remaining_next == 32'd0) begin
          phase_next = hrf_pkg::PH_DONE;
        end
      end
      hrf_pkg::PH_DONE: phase_next = hrf_pkg::PH_DONE;
      default:          phase_next = hrf_pkg::PH_DONE;
    endcase
  end

  // result beat
  always_comb begin
    res             = '0;
    res.out_byte    = s_tdata;
    res.status      = hrf_pkg::ST_OK;
    res_valid       = data_acc && (phase != hrf_pkg::PH_DONE);
    unique case (phase)
      hrf_pkg::PH_HEADER: begin
        if (done_hdr) begin
          res.hdr_end = 1'b1;
          res.status  = hdr_status;
          if (hdr_status != hrf_pkg::ST_OK) begin
            res.last = 1'b1;
          end else begin
            res.body_length = body_len;
            res.last        = (body_len == 32'd0);
          end
        end else if (hdr_over) begin
          res.last   = 1'b1;
          res.status = hrf_pkg::ST_HDR_LARGE;
        end
      end
      hrf_pkg::PH_BODY: begin
        res.in_body = 1'b1;
        res.last    = (remaining_next == 32'd0);
      end
      hrf_pkg::PH_DONE: res_valid = 1'b0;
      default:          res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (in_acc && s_tuser == hrf_pkg::CMD_START)) begin
      phase        <= hrf_pkg::PH_HEADER;
      term         <= 2'd0;
      header_count <= '0;
      remaining    <= 32'd0;
    end else if (data_acc) begin
      phase <= phase_next;
      if (phase == hrf_pkg::PH_HEADER) begin
        term         <= term_next;
        header_count <= header_count_next;
        if (done_hdr) begin
          remaining <= body_len;
        end
      end else if (phase == hrf_pkg::PH_BODY) begin
        remaining <= remaining_next;
      end
    end
  end

  // ---------------- output register and skid ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, out_res.body_length, 3'(out_res.status), out_res.out_byte};
  assign m_tuser  = {out_res.hdr_end, out_res.in_body};
  assign m_tlast  = out_res.last;

`ifndef SYNTHESIS
  // skid holds a beat only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // any error status closes the request
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status != hrf_pkg::ST_OK) |-> out_res.last)
    else $error("error status without last");

  // an error carries no body length
  a_err_no_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status != hrf_pkg::ST_OK) |-> (out_res.body_length == 32'd0))
    else $error("error status with nonzero body length");

  // body beats never mark the header end
  a_body_not_hdr_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.in_body) |-> !out_res.hdr_end)
    else $error("body beat flagged as header end");

  // a start command restarts header parsing
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tuser == hrf_pkg::CMD_START) |=>
      (phase == hrf_pkg::PH_HEADER && header_count == '0 && term == 2'd0))
    else $error("start command did not clear framing state");
`endif

endmodule

>>> sim/http_request_framer_test.sv
// Self-checking bench for http_request_framer: byte stream in, framed beats out, APB limits.
// Holds its own model of the header parser and body counter; depends on hrf_pkg and the RTL.
package hrf_check_pkg;

  localparam logic [8*17-1:0] ENC_WORD = "transfer-encoding";
  localparam logic [8*14-1:0] LEN_WORD = "content-length";

  class request_framing;
    logic [15:0] hdr_limit;
    logic [31:0] body_limit;

    hrf_pkg::phase_t phase;
    logic [1:0]  term_step;
    logic [16:0] hdr_count;
    bit          in_value;
    logic [4:0]  key_pos;
    bit          len_key_ok;
    bit          enc_key_ok;
    bit          in_len_value;
    bit          len_seen;
    bit          enc_seen;
    bit          len_bad;
    logic [3:0]  digits;
    bit          past_blank;
    bit          held_cr;
    logic [39:0] len_value;
    logic [31:0] body_left;

    hrf_pkg::out_res_t pending_beats[$];
    int faults;
    int hdr_ends;
    int body_beats;
    int dropped;
    int status_hits[5];

    function new();
      hdr_limit  = hrf_pkg::MAX_HEADER_RESET;
      body_limit = hrf_pkg::MAX_BODY_RESET;
      restart();
    endfunction

    function void restart();
      phase        = hrf_pkg::PH_HEADER;
      term_step    = '0;
      hdr_count    = '0;
      in_value     = 1'b0;
      key_pos      = '0;
      len_key_ok   = 1'b1;
      enc_key_ok   = 1'b1;
      in_len_value = 1'b0;
      len_seen     = 1'b0;
      enc_seen     = 1'b0;
      len_bad      = 1'b0;
      digits       = '0;
      past_blank   = 1'b0;
      held_cr      = 1'b0;
      len_value    = '0;
      body_left    = '0;
    endfunction

    function void set_limit(hrf_pkg::reg_index_t idx, logic [31:0] val);
      if (idx == hrf_pkg::REG_MAX_HEADER) hdr_limit = val[15:0];
      else body_limit = val;
    endfunction

    static function logic [7:0] word_char(logic [8*17-1:0] word, int n, int pos);
      return word[8*(n-1-pos) +: 8];
    endfunction

    function void close_line();
      if (in_len_value && digits == 0) len_bad = 1'b1;
      in_len_value = 1'b0;
      in_value     = 1'b0;
      key_pos      = '0;
      len_key_ok   = 1'b1;
      enc_key_ok   = 1'b1;
    endfunction

    function void value_char(logic [7:0] c);
      logic [39:0] dig;
      if (!in_len_value || len_bad) return;
      if (c == hrf_pkg::CH_SPACE || c == hrf_pkg::CH_TAB) begin
        if (digits != 0) past_blank = 1'b1;
      end else if (c >= hrf_pkg::CH_0 && c <= hrf_pkg::CH_9 && !past_blank) begin
        dig = 40'(c - hrf_pkg::CH_0);
        if (digits <= hrf_pkg::MAX_LENGTH_DIGITS) digits++;
        if (digits > hrf_pkg::MAX_LENGTH_DIGITS) begin
          len_bad = 1'b1;
          return;
        end
        // saturate instead of wrapping
        if (len_value > (hrf_pkg::LEN_CAP - dig) / 10) len_value = hrf_pkg::LEN_CAP;
        else len_value = len_value * 10 + dig;
      end else begin
        len_bad = 1'b1;
      end
    endfunction

    function void line_char(logic [7:0] c);
      logic [7:0] lc;
      if (in_value) begin
        value_char(c);
        return;
      end
      if (c == hrf_pkg::CH_COLON) begin
        if (enc_key_ok && key_pos == hrf_pkg::ENC_KEY_LEN) enc_seen = 1'b1;
        if (len_key_ok && key_pos == hrf_pkg::LEN_KEY_LEN && !len_seen) begin
          len_seen     = 1'b1;
          in_len_value = 1'b1;
        end
        in_value = 1'b1;
        return;
      end
      lc = (c >= hrf_pkg::CH_A_UP && c <= hrf_pkg::CH_Z_UP) ? c + hrf_pkg::CASE_GAP : c;
      if (key_pos >= hrf_pkg::ENC_KEY_LEN ||
          word_char(ENC_WORD, hrf_pkg::ENC_KEY_LEN, key_pos) != lc)
        enc_key_ok = 1'b0;
      if (key_pos >= hrf_pkg::LEN_KEY_LEN ||
          word_char(LEN_WORD, hrf_pkg::LEN_KEY_LEN, key_pos) != lc)
        len_key_ok = 1'b0;
      if (key_pos < hrf_pkg::KEY_POS_CAP) key_pos++;
    endfunction

    // A CR only ends a line when an LF follows; otherwise it is line content.
    function void parse_char(logic [7:0] c);
      if (held_cr) begin
        held_cr = 1'b0;
        if (c == hrf_pkg::CH_LF) begin
          close_line();
          return;
        end
        line_char(hrf_pkg::CH_CR);
      end
      if (c == hrf_pkg::CH_CR) held_cr = 1'b1;
      else line_char(c);
    endfunction

    function void take_byte(logic cmd, logic [7:0] c);
      hrf_pkg::out_res_t r;
      bit                hdr_done;
      hrf_pkg::status_t  st;
      if (cmd == hrf_pkg::CMD_START) begin
        restart();
        return;
      end
      if (phase == hrf_pkg::PH_DONE) begin
        dropped++;
        return;
      end
      r = '0;
      r.out_byte = c;
      if (phase == hrf_pkg::PH_BODY) begin
        r.in_body = 1'b1;
        body_beats++;
        if (body_left != 0) body_left--;
        if (body_left == 0) begin
          r.last = 1'b1;
          phase  = hrf_pkg::PH_DONE;
        end
        pending_beats.push_back(r);
        return;
      end

      if (hdr_count != hrf_pkg::CNT_CAP) hdr_count++;
      hdr_done = 1'b0;
      if (c == hrf_pkg::CH_CR) begin
        term_step = (term_step == 2'd2) ? 2'd3 : 2'd1;
      end else if (c == hrf_pkg::CH_LF) begin
        hdr_done  = (term_step == 2'd3);
        term_step = (term_step == 2'd1) ? 2'd2 : 2'd0;
      end else begin
        term_step = 2'd0;
      end
      parse_char(c);

      if (!hdr_done) begin
        if (hdr_count > 17'(hdr_limit)) begin
          r.last   = 1'b1;
          r.status = hrf_pkg::ST_HDR_LARGE;
          phase    = hrf_pkg::PH_DONE;
          status_hits[hrf_pkg::ST_HDR_LARGE]++;
        end
        pending_beats.push_back(r);
        return;
      end

      r.hdr_end = 1'b1;
      hdr_ends++;
      st = hrf_pkg::ST_OK;
      if (enc_seen) st = hrf_pkg::ST_TRANSFER_ENC;
      else if (len_seen && len_bad) st = hrf_pkg::ST_BAD_LENGTH;
      else if (len_seen && len_value > {8'h00, body_limit}) st = hrf_pkg::ST_BODY_LARGE;
      status_hits[st]++;
      if (st != hrf_pkg::ST_OK) begin
        r.last   = 1'b1;
        r.status = st;
        phase    = hrf_pkg::PH_DONE;
      end else begin
        body_left     = len_seen ? len_value[31:0] : 32'd0;
        r.body_length = body_left;
        if (body_left == 0) begin
          r.last = 1'b1;
          phase  = hrf_pkg::PH_DONE;
        end else begin
          phase = hrf_pkg::PH_BODY;
        end
      end
      pending_beats.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        faults++;
      end
    endfunction

    function void match_out_beat(hrf_pkg::out_res_t got);
      hrf_pkg::out_res_t want;
      if (pending_beats.size() == 0) begin
        $display("%0t: output beat with nothing pending, expected none, got %h", $time, got);
        faults++;
        return;
      end
      want = pending_beats.pop_front();
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("in_body", want.in_body, got.in_body);
      check_field("hdr_end", want.hdr_end, got.hdr_end);
      check_field("last", want.last, got.last);
      check_field("status", want.status, got.status);
      check_field("body_length", want.body_length, got.body_length);
    endfunction
  endclass
endpackage

module http_request_framer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  http_request_framer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  hrf_check_pkg::request_framing book;
  logic [7:0] req_bytes[$];
  int  body_hint;
  int  length_lines;
  bit  eager;
  int  beats_sent;
  int  requests;
  int  settings;
  int  idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // receiver: ready runs of random length broken by stalls
  initial begin
    int run;
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap(1'b0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    hrf_pkg::out_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.out_byte    = m_tdata[7:0];
      got.status      = hrf_pkg::status_t'(m_tdata[10:8]);
      got.body_length = m_tdata[42:11];
      got.in_body     = m_tuser[0];
      got.hdr_end     = m_tuser[1];
      got.last        = m_tlast;
      book.match_out_beat(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_beat(input logic cmd, input logic [7:0] b);
    int gap;
    gap = pick_gap(eager);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.take_byte(cmd, b);
    beats_sent++;
  endtask

  // drop valid and hold until every pending beat is out
  task automatic settle(input int extra);
    s_tvalid <= 1'b0;
    while (book.pending_beats.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input hrf_pkg::reg_index_t idx, input logic [31:0] val);
    logic [31:0] want;
    want = (idx == hrf_pkg::REG_MAX_HEADER) ? {16'h0000, val[15:0]} : val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    book.set_limit(idx, val);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %s readback, expected %0h, got %0h", $time, idx.name(), want,
               prdata);
      book.faults++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_text(input string s, input bit mix);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (mix && ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1) == 1)
        ch = ch - hrf_pkg::CASE_GAP;
      req_bytes.push_back(ch);
    end
  endtask

  task automatic push_crlf();
    req_bytes.push_back(hrf_pkg::CH_CR);
    req_bytes.push_back(hrf_pkg::CH_LF);
  endtask

  task automatic push_blank();
    repeat ($urandom_range(0, 2))
      req_bytes.push_back($urandom_range(0, 1) ? hrf_pkg::CH_SPACE : hrf_pkg::CH_TAB);
  endtask

  task automatic push_junk(input int n);
    repeat (n) req_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic longint unsigned pick_length(input logic [31:0] cap);
    case ($urandom_range(0, 5))
      0:       return 0;
      1, 2:    return $urandom_range(1, 24);
      3:       return 64'(cap);
      4:       return 64'(cap) + 1;
      default: return 64'($urandom_range(0, 999999)) * 1000000 + $urandom_range(0, 999999);
    endcase
  endfunction

  task automatic push_header_line();
    longint unsigned n;
    string near_keys[7] = '{"content-lengt", "content-lengthh", "transfer-encodin",
                            "transfer-encodingx", " content-length", "content.length",
                            "transfer encoding"};
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = pick_length(book.body_limit);
        push_text("content-length:", 1'b1);
        push_blank();
        if ($urandom_range(0, 4) == 0) push_text("0", 1'b0);
        push_text($sformatf("%0d", n), 1'b0);
        push_blank();
        if (length_lines == 0 && n <= 40) body_hint = int'(n);
        length_lines++;
      end
      3: begin
        push_text("content-length:", 1'b1);
        push_blank();
        case ($urandom_range(0, 5))
          0:       ;                                    // empty value
          1:       push_text("12 3", 1'b0);             // digit after a blank
          2:       push_text("1000000000000", 1'b0);    // one digit too many
          3:       push_text("+5", 1'b0);
          4:       push_text("0x1f", 1'b0);
          default: push_text("000000000007", 1'b0);     // exactly the digit limit
        endcase
        length_lines++;
      end
      4: begin
        push_text("transfer-encoding:", 1'b1);
        push_blank();
        push_text("chunked", 1'b0);
      end
      5: begin
        push_text(near_keys[$urandom_range(0, 6)], 1'b1);
        push_text(": 9", 1'b0);
      end
      6: begin
        // bare CR or LF inside the key or value
        if ($urandom_range(0, 1) == 1) push_text("content-length", 1'b1);
        else push_text("x-note: 1", 1'b1);
        req_bytes.push_back($urandom_range(0, 1) ? hrf_pkg::CH_CR : hrf_pkg::CH_LF);
        push_text(":3", 1'b0);
      end
      7:       push_text("no colon here", 1'b0);
      8:       push_junk($urandom_range(0, 12));
      default: push_text("host: example.org", 1'b1);
    endcase
    push_crlf();
  endtask

  task automatic build_request();
    int cut;
    req_bytes.delete();
    body_hint    = -1;
    length_lines = 0;
    case ($urandom_range(0, 3))
      0:       push_text("GET / HTTP/1.1", 1'b0);
      1:       push_text("POST /submit HTTP/1.1", 1'b0);
      2:       push_text("PUT /item/7 HTTP/1.0", 1'b0);
      default: push_junk($urandom_range(0, 10));
    endcase
    push_crlf();
    repeat ($urandom_range(0, 5)) push_header_line();
    push_crlf();
    if (body_hint > 0) push_junk(body_hint);
    // trailing bytes past the body are dropped
    if ($urandom_range(0, 3) == 0) push_junk($urandom_range(1, 4));
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, req_bytes.size());
      while (req_bytes.size() > cut) void'(req_bytes.pop_back());
    end
  endtask

  task automatic build_noise();
    req_bytes.delete();
    repeat ($urandom_range(1, 30)) begin
      case ($urandom_range(0, 3))
        0:       req_bytes.push_back(hrf_pkg::CH_CR);
        1:       req_bytes.push_back(hrf_pkg::CH_LF);
        2:       req_bytes.push_back(hrf_pkg::CH_COLON);
        default: req_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic run_request();
    if ($urandom_range(0, 9) == 0) build_noise();
    else build_request();
    eager = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) != 0) send_beat(hrf_pkg::CMD_START, 8'($urandom_range(0, 255)));
    foreach (req_bytes[i]) send_beat(hrf_pkg::CMD_DATA, req_bytes[i]);
    requests++;
    if ($urandom_range(0, 11) == 0) settle(0);
  endtask

  task automatic run_phase(input logic [15:0] hdr_max, input logic [31:0] body_max);
    int first;
    settle(4);
    write_reg(hrf_pkg::REG_MAX_HEADER, {16'h0000, hdr_max});
    write_reg(hrf_pkg::REG_MAX_BODY, body_max);
    settings++;
    first = beats_sent;
    while (beats_sent - first < 190) run_request();
  endtask

  initial begin
    book = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tuser  <= hrf_pkg::CMD_DATA;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    eager    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bare terminator: zero length, then a dropped byte
    req_bytes.delete();
    push_crlf();
    push_crlf();
    send_beat(hrf_pkg::CMD_START, 8'hFF);
    foreach (req_bytes[i]) send_beat(hrf_pkg::CMD_DATA, req_bytes[i]);
    send_beat(hrf_pkg::CMD_DATA, 8'h78);
    // one body byte, the next one dropped
    req_bytes.delete();
    push_text("Content-Length:1", 1'b0);
    push_crlf();
    push_crlf();
    req_bytes.push_back(8'hFF);
    req_bytes.push_back(8'h00);
    send_beat(hrf_pkg::CMD_START, 8'h00);
    foreach (req_bytes[i]) send_beat(hrf_pkg::CMD_DATA, req_bytes[i]);

    run_phase(16'hFFFF, 32'hFFFF_FFFF);
    run_phase(16'h0000, 32'h0000_0000);
    run_phase(16'($urandom_range(30, 120)), 32'd16);
    run_phase(16'd8192, 32'd5);
    run_phase(16'($urandom_range(40, 200)), 32'($urandom_range(0, 1000)));
    run_phase(16'hFFFF, 32'd1048576);

    // header that runs past a small limit
    settle(4);
    eager = 1'b0;
    write_reg(hrf_pkg::REG_MAX_HEADER, 32'd100);
    send_beat(hrf_pkg::CMD_START, 8'h00);
    repeat (140) send_beat(hrf_pkg::CMD_DATA, 8'($urandom_range(8'h61, 8'h7A)));
    requests++;

    run_phase(16'($urandom_range(0, 65535)), $urandom());
    run_phase(16'($urandom_range(20, 60)), 32'($urandom_range(0, 30)));

    settle(8);
    $display("Ran %0d requests, %0d bytes in, %0d limit settings: %0d header ends, %0d body beats",
             requests, beats_sent, settings, book.hdr_ends, book.body_beats);
    $display("Status ok/hdr/te/len/body %0d/%0d/%0d/%0d/%0d, %0d bytes dropped",
             book.status_hits[0], book.status_hits[1], book.status_hits[2],
             book.status_hits[3], book.status_hits[4], book.dropped);
    if (book.faults == 0 && book.pending_beats.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
